// ===== sv/hcg_pkg.sv =====
// Shared types, constants and coefficient tables of the HSBC CSC coefficient generator.
package hcg_pkg;

    typedef enum logic [1:0] {
        CS_601_LIM  = 2'd0,
        CS_709_LIM  = 2'd1,
        CS_601_FULL = 2'd2,
        CS_709_FULL = 2'd3
    } cs_sel_t;

    typedef struct packed {
        logic              rgb;
        cs_sel_t           cs_sel;
        logic signed [7:0] br;
        logic [7:0]        ct;
        logic [7:0]        st;
        logic [5:0]        hu;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t data;
    } req_xfer_t;

    localparam int HCG_QDEPTH = 2;
    localparam int HCG_QPTR_W = (HCG_QDEPTH > 1) ? $clog2(HCG_QDEPTH) : 1;
    localparam int HCG_QCNT_W = $clog2(HCG_QDEPTH + 1);

    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam logic [3:0] COEF_LAST = 4'd11;
    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] COL_OFFSET = 2'd3;

    localparam logic signed [45:0] GAIN_MAX = 46'sd4095;
    localparam logic signed [45:0] GAIN_MIN = -46'sd4096;
    localparam logic signed [45:0] OFFS_MAX = 46'sd8091;
    localparam logic signed [45:0] OFFS_MIN = -46'sd8092;

    localparam logic signed [13:0] Y2R [4][3][4] = '{
        '{'{14'sd1192, 14'sd0, 14'sd1634, -14'sd3269},
          '{14'sd1192, -14'sd401, -14'sd833, 14'sd2467},
          '{14'sd1192, 14'sd2066, 14'sd0, -14'sd4131}},
        '{'{14'sd1192, 14'sd0, 14'sd1836, -14'sd3970},
          '{14'sd1192, -14'sd218, -14'sd546, 14'sd1230},
          '{14'sd1192, 14'sd2163, 14'sd0, -14'sd4624}},
        '{'{14'sd1024, 14'sd0, 14'sd1436, -14'sd2871},
          '{14'sd1024, -14'sd352, -14'sd731, 14'sd2167},
          '{14'sd1024, 14'sd1815, 14'sd0, -14'sd3629}},
        '{'{14'sd1024, 14'sd0, 14'sd1613, -14'sd3225},
          '{14'sd1024, -14'sd192, -14'sd479, 14'sd1342},
          '{14'sd1024, 14'sd1900, 14'sd0, -14'sd3800}}
    };

    localparam logic signed [18:0] R2Y [4][4] = '{
        '{19'sd218, 19'sd732, 19'sd74, 19'sd0},
        '{-19'sd116, -19'sd394, 19'sd512, 19'sd131072},
        '{19'sd512, -19'sd464, -19'sd46, 19'sd131072},
        '{19'sd0, 19'sd0, 19'sd0, 19'sd1024}
    };

    localparam logic signed [13:0] SINE_LUT [64] = '{
        -14'sd1985, -14'sd1922, -14'sd1859, -14'sd1795, -14'sd1731, -14'sd1665,
        -14'sd1600, -14'sd1534, -14'sd1467, -14'sd1400, -14'sd1333, -14'sd1265,
        -14'sd1197, -14'sd1129, -14'sd1060, -14'sd990, -14'sd921, -14'sd851,
        -14'sd781, -14'sd711, -14'sd640, -14'sd570, -14'sd499, -14'sd428,
        -14'sd356, -14'sd285, -14'sd214, -14'sd142, -14'sd71, 14'sd0,
        14'sd71, 14'sd142, 14'sd214, 14'sd285, 14'sd356, 14'sd428,
        14'sd499, 14'sd570, 14'sd640, 14'sd711, 14'sd781, 14'sd851,
        14'sd921, 14'sd990, 14'sd1060, 14'sd1129, 14'sd1197, 14'sd1265,
        14'sd1333, 14'sd1400, 14'sd1467, 14'sd1534, 14'sd1600, 14'sd1665,
        14'sd1731, 14'sd1795, 14'sd1859, 14'sd1922, 14'sd1985,
        14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0
    };

    localparam logic signed [13:0] COS_LUT [64] = '{
        14'sd3582, 14'sd3616, 14'sd3649, 14'sd3681, 14'sd3712, 14'sd3741,
        14'sd3770, 14'sd3797, 14'sd3823, 14'sd3848, 14'sd3872, 14'sd3895,
        14'sd3917, 14'sd3937, 14'sd3956, 14'sd3974, 14'sd3991, 14'sd4006,
        14'sd4020, 14'sd4033, 14'sd4045, 14'sd4056, 14'sd4065, 14'sd4073,
        14'sd4080, 14'sd4086, 14'sd4090, 14'sd4093, 14'sd4095, 14'sd4096,
        14'sd4095, 14'sd4093, 14'sd4090, 14'sd4086, 14'sd4080, 14'sd4073,
        14'sd4065, 14'sd4056, 14'sd4045, 14'sd4033, 14'sd4020, 14'sd4006,
        14'sd3991, 14'sd3974, 14'sd3956, 14'sd3937, 14'sd3917, 14'sd3895,
        14'sd3872, 14'sd3848, 14'sd3823, 14'sd3797, 14'sd3770, 14'sd3741,
        14'sd3712, 14'sd3681, 14'sd3649, 14'sd3616, 14'sd3582,
        14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0
    };

    // Division by 100 through a reciprocal; exact for x up to 18000.
    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(13'd5243);
        return p[26:19];
    endfunction

endpackage

// ===== sv/hcg_req_if.sv =====
// Request channel carrying one set of picture adjustment settings.
interface hcg_req_if;
    logic       valid;
    logic       ready;
    logic       rgb_input;
    logic [2:0] csc_standard;
    logic [6:0] brightness;
    logic [6:0] contrast_level;
    logic [6:0] saturation_level;
    logic [6:0] hue_level;

    modport source(output valid, rgb_input, csc_standard, brightness, contrast_level,
                   saturation_level, hue_level, input ready);
    modport sink(input valid, rgb_input, csc_standard, brightness, contrast_level,
                 saturation_level, hue_level, output ready);
endinterface

// ===== sv/hcg_coef_if.sv =====
// Coefficient channel carrying one CSC coefficient per transaction.
interface hcg_coef_if;
    logic               valid;
    logic               ready;
    logic [3:0]         coef_index;
    logic signed [13:0] coef_value;
    logic               last;

    modport source(output valid, coef_index, coef_value, last, input ready);
    modport sink(input valid, coef_index, coef_value, last, output ready);
endinterface

// ===== sv/hcg_front.sv =====
// Request front end: clamps and scales the settings and selects the output matrix.
module hcg_front (
    hcg_req_if.sink          req,
    input  logic             push_ready,
    output hcg_pkg::req_xfer_t push
);

    logic [6:0]  br_pct;
    logic [6:0]  ct_pct;
    logic [6:0]  st_pct;
    logic [6:0]  hu_pct;
    logic [7:0]  br_q;
    logic [7:0]  ct_q;
    logic [7:0]  st_q;
    logic [7:0]  hu_q;
    logic signed [8:0] br_s;

    always_comb
    begin
        br_pct = (req.brightness > hcg_pkg::PCT_MAX) ? hcg_pkg::PCT_MAX : req.brightness;
        ct_pct = (req.contrast_level > hcg_pkg::PCT_MAX) ? hcg_pkg::PCT_MAX
                                                          : req.contrast_level;
        st_pct = (req.saturation_level > hcg_pkg::PCT_MAX) ? hcg_pkg::PCT_MAX
                                                            : req.saturation_level;
        hu_pct = (req.hue_level > hcg_pkg::PCT_MAX) ? hcg_pkg::PCT_MAX : req.hue_level;

        br_q = hcg_pkg::div100(15'(br_pct) << 7);
        ct_q = hcg_pkg::div100(15'(ct_pct) * 15'd180);
        st_q = hcg_pkg::div100(15'(st_pct) << 7);
        hu_q = hcg_pkg::div100(15'(hu_pct) * 15'd58);
        br_s = $signed({1'b0, br_q}) - 9'sd64;

        push.valid       = req.valid;
        push.data.rgb    = req.rgb_input;
        unique case (req.csc_standard)
            3'd1:    push.data.cs_sel = hcg_pkg::CS_709_LIM;
            3'd2:    push.data.cs_sel = hcg_pkg::CS_601_FULL;
            3'd3:    push.data.cs_sel = hcg_pkg::CS_709_FULL;
            default: push.data.cs_sel = hcg_pkg::CS_601_LIM;
        endcase
        push.data.br = br_s[7:0];
        push.data.ct = ct_q + 8'd38;
        push.data.st = st_q + 8'd64;
        push.data.hu = hu_q[5:0];
    end

    assign req.ready = push_ready;

endmodule

// ===== sv/hcg_queue.sv =====
// Short request queue between the front end and the coefficient sequencer.
module hcg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcg_pkg::req_xfer_t   push,
    output logic                 push_ready,
    output hcg_pkg::req_xfer_t   head,
    input  logic                 pop
);

    hcg_pkg::req_t                   mem_reg [hcg_pkg::HCG_QDEPTH];
    logic [hcg_pkg::HCG_QPTR_W-1:0]  wr_ptr_reg;
    logic [hcg_pkg::HCG_QPTR_W-1:0]  wr_ptr_next;
    logic [hcg_pkg::HCG_QPTR_W-1:0]  rd_ptr_reg;
    logic [hcg_pkg::HCG_QPTR_W-1:0]  rd_ptr_next;
    logic [hcg_pkg::HCG_QCNT_W-1:0]  count_reg;
    logic [hcg_pkg::HCG_QCNT_W-1:0]  count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [hcg_pkg::HCG_QPTR_W-1:0] PTR_LAST =
        hcg_pkg::HCG_QPTR_W'(hcg_pkg::HCG_QDEPTH - 1);
    localparam logic [hcg_pkg::HCG_QCNT_W-1:0] CNT_FULL =
        hcg_pkg::HCG_QCNT_W'(hcg_pkg::HCG_QDEPTH);

    always_comb
    begin
        push_ready  = (count_reg != CNT_FULL);
        head.valid  = (count_reg != '0);
        head.data   = mem_reg[rd_ptr_reg];
        do_push     = push.valid && push_ready;
        do_pop      = pop && head.valid;
        wr_ptr_next = do_push ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1)
                              : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1)
                             : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

// ===== sv/hcg_back.sv =====
// Coefficient sequencer: builds the adjustment matrix and emits the twelve coefficients.
module hcg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hcg_pkg::req_xfer_t head,
    output logic               pop,
    hcg_coef_if.source         coef
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_K1   = 6'b000010,
        S_K2   = 6'b000100,
        S_H    = 6'b001000,
        S_COL  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;
    logic [1:0] col_reg;
    logic [1:0] col_next;
    logic       p_valid_reg;
    logic       p_valid_next;
    logic       o_valid_reg;
    logic       o_valid_next;

    hcg_pkg::req_t      item_reg;
    logic [15:0]        ctst_reg;
    logic signed [12:0] k11_reg;
    logic signed [12:0] k12_reg;
    logic signed [12:0] k21_reg;
    logic [10:0]        h00_reg;
    logic signed [19:0] h03_reg;
    logic signed [21:0] h13_reg;
    logic signed [21:0] h23_reg;
    logic signed [23:0] cur_reg [4][4];
    logic signed [43:0] p_prod_reg [4];
    logic [1:0]         p_col_reg;
    logic [3:0]         p_idx_reg;
    logic [3:0]         o_idx_reg;
    logic signed [13:0] o_value_reg;

    logic               en;
    logic               issue;
    logic               run_end;
    logic signed [31:0] pc;
    logic signed [31:0] ps;
    logic signed [31:0] ps_neg;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] t4;
    logic signed [31:0] h03_w;
    logic signed [31:0] h13_w;
    logic signed [31:0] h23_w;
    logic signed [23:0] col_val [4];
    logic signed [19:0] m_val [4];
    logic               is_off;
    logic signed [45:0] acc;
    logic signed [45:0] sh;
    logic signed [13:0] sat;

    assign en      = !o_valid_reg || coef.ready;
    assign run_end = (state_reg == S_EMIT) && en && (row_reg == hcg_pkg::ROW_LAST)
                     && (col_reg == hcg_pkg::COL_OFFSET);
    assign issue   = (state_reg == S_EMIT) && en;
    assign pop     = head.valid && ((state_reg == S_IDLE) || run_end);

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = S_K1;
                end
            end
            S_K1: state_next = S_K2;
            S_K2: state_next = S_H;
            S_H:
            begin
                state_next = S_COL;
                col_next   = '0;
                row_next   = '0;
            end
            S_COL:
            begin
                col_next = col_reg + 1'b1;
                if (col_reg == hcg_pkg::COL_OFFSET)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (en)
                begin
                    col_next = col_reg + 1'b1;
                    if (col_reg == hcg_pkg::COL_OFFSET)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    if (run_end)
                    begin
                        state_next = head.valid ? S_K1 : S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        p_valid_next = en ? issue : p_valid_reg;
        o_valid_next = en ? p_valid_reg : o_valid_reg;
    end

    // Setup arithmetic: hue rotation terms and the HSBC matrix entries.
    always_comb
    begin
        pc     = 32'($signed({1'b0, ctst_reg})) * 32'(hcg_pkg::COS_LUT[item_reg.hu]);
        ps     = 32'($signed({1'b0, ctst_reg})) * 32'(hcg_pkg::SINE_LUT[item_reg.hu]);
        ps_neg = -ps;
        h03_w  = 32'(item_reg.br) * 32'sd2048
                 + (32'sd1024 - 32'($signed({1'b0, item_reg.ct})) * 32'sd8) * 32'sd16;
        h13_w  = (32'sd1024 - (32'(k11_reg) + 32'(k12_reg))) * 32'sd128;
        h23_w  = (32'sd1024 - (32'(k21_reg) + 32'(k11_reg))) * 32'sd128;
    end

    // One column of the working matrix per cycle.
    always_comb
    begin
        t0 = 32'($signed({1'b0, h00_reg})) * 32'(hcg_pkg::R2Y[0][col_reg]);
        t1 = 32'(k11_reg) * 32'(hcg_pkg::R2Y[1][col_reg]);
        t2 = 32'(k12_reg) * 32'(hcg_pkg::R2Y[2][col_reg]);
        t3 = 32'(k21_reg) * 32'(hcg_pkg::R2Y[1][col_reg]);
        t4 = 32'(k11_reg) * 32'(hcg_pkg::R2Y[2][col_reg]);
        if (item_reg.rgb)
        begin
            col_val[0] = 24'((t0 >>> 10) + ((col_reg == hcg_pkg::COL_OFFSET)
                             ? 32'(h03_reg) : 32'sd0));
            col_val[1] = 24'((t1 >>> 10) + (t2 >>> 10) + ((col_reg == hcg_pkg::COL_OFFSET)
                             ? 32'(h13_reg) : 32'sd0));
            col_val[2] = 24'((t3 >>> 10) + (t4 >>> 10) + ((col_reg == hcg_pkg::COL_OFFSET)
                             ? 32'(h23_reg) : 32'sd0));
        end
        else
        begin
            case (col_reg)
                2'd0:
                begin
                    col_val[0] = 24'($signed({1'b0, h00_reg}));
                    col_val[1] = '0;
                    col_val[2] = '0;
                end
                2'd1:
                begin
                    col_val[0] = '0;
                    col_val[1] = 24'(k11_reg);
                    col_val[2] = 24'(k21_reg);
                end
                2'd2:
                begin
                    col_val[0] = '0;
                    col_val[1] = 24'(k12_reg);
                    col_val[2] = 24'(k11_reg);
                end
                default:
                begin
                    col_val[0] = 24'(h03_reg);
                    col_val[1] = 24'(h13_reg);
                    col_val[2] = 24'(h23_reg);
                end
            endcase
        end
        col_val[3] = (col_reg == hcg_pkg::COL_OFFSET) ? 24'sd1024 : 24'sd0;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            m_val[c] = 20'(hcg_pkg::Y2R[item_reg.cs_sel][row_reg][c]);
        end
        m_val[3] = 20'(hcg_pkg::Y2R[item_reg.cs_sel][row_reg][3]) * 20'sd64;
        acc = 46'(p_prod_reg[0]) + 46'(p_prod_reg[1]) + 46'(p_prod_reg[2])
              + 46'(p_prod_reg[3]);
        is_off = (p_col_reg == hcg_pkg::COL_OFFSET);
        if (is_off)
        begin
            sh = acc >>> 16;
            if (sh > hcg_pkg::OFFS_MAX)
            begin
                sat = 14'(hcg_pkg::OFFS_MAX);
            end
            else if (sh < hcg_pkg::OFFS_MIN)
            begin
                sat = 14'(hcg_pkg::OFFS_MIN);
            end
            else
            begin
                sat = sh[13:0];
            end
        end
        else
        begin
            sh = acc >>> 10;
            if (sh > hcg_pkg::GAIN_MAX)
            begin
                sat = 14'(hcg_pkg::GAIN_MAX);
            end
            else if (sh < hcg_pkg::GAIN_MIN)
            begin
                sat = 14'(hcg_pkg::GAIN_MIN);
            end
            else
            begin
                sat = sh[13:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.data;
        end
        if (state_reg == S_K1)
        begin
            ctst_reg <= 16'(item_reg.ct * item_reg.st);
        end
        if (state_reg == S_K2)
        begin
            k11_reg <= 13'(pc >>> 16);
            k12_reg <= 13'(ps >>> 16);
            k21_reg <= 13'(ps_neg >>> 16);
        end
        if (state_reg == S_H)
        begin
            h00_reg <= {item_reg.ct, 3'b000};
            h03_reg <= h03_w[19:0];
            h13_reg <= h13_w[21:0];
            h23_reg <= h23_w[21:0];
        end
        if (state_reg == S_COL)
        begin
            for (int r = 0; r < 4; r++)
            begin
                cur_reg[r][col_reg] <= col_val[r];
            end
        end
        if (issue)
        begin
            for (int c = 0; c < 4; c++)
            begin
                p_prod_reg[c] <= 44'(m_val[c]) * 44'(cur_reg[c][col_reg]);
            end
            p_col_reg <= col_reg;
            p_idx_reg <= {row_reg, col_reg};
        end
        if (en)
        begin
            o_idx_reg   <= p_idx_reg;
            o_value_reg <= sat;
        end
    end

    assign coef.valid      = o_valid_reg;
    assign coef.coef_index = o_idx_reg;
    assign coef.coef_value = o_value_reg;
    assign coef.last       = (o_idx_reg == hcg_pkg::COEF_LAST);

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && coef.last |-> coef.coef_index == hcg_pkg::COEF_LAST)
        else $error("last flag away from the final coefficient");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> row_reg != 2'd3)
        else $error("row counter past the last matrix row");

    a_pop_when: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE) || run_end)
        else $error("request taken while a run is in progress");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && coef.coef_index[1:0] != hcg_pkg::COL_OFFSET
        |-> coef.coef_value <= 14'sd4095 && coef.coef_value >= -14'sd4096)
        else $error("gain coefficient outside its range");

    a_run_follow: assert property (@(posedge clk) disable iff (!rst_n)
        run_end |=> p_valid_reg && p_idx_reg == hcg_pkg::COEF_LAST)
        else $error("final coefficient not issued at the end of a run");

endmodule

// ===== sv/hsbc_csc_coefficient_generator_unit.sv =====
// Top level of the HSBC color adjustment CSC coefficient generator.
// Each accepted request produces twelve coefficient transactions in row-major order,
// index row*4+column, the offset term in column three and last set on index eleven.
// The sequencer takes the next queued request as a run ends; it works through the hue
// and matrix setup states (K1, K2, H), builds the working matrix one column a cycle,
// and issues one coefficient a cycle while coef.ready is high into a two-stage
// multiply and saturate pipeline. A two-entry request queue lets req accept new
// settings while earlier coefficients are still being generated or held back.
module hsbc_csc_coefficient_generator_unit (
    input  logic       clk,
    input  logic       rst_n,
    hcg_req_if.sink    req,
    hcg_coef_if.source coef
);

    hcg_pkg::req_xfer_t push;
    hcg_pkg::req_xfer_t head;
    logic               push_ready;
    logic               pop;

    hcg_front u_front (
        .req        (req),
        .push_ready (push_ready),
        .push       (push)
    );

    hcg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    hcg_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .coef  (coef)
    );

endmodule

// ===== test/tb_hsbc_csc_coefficient_generator_unit.sv =====
// Testbench for the HSBC CSC coefficient generator: directed and random settings.
`timescale 1ns / 100ps

module tb_hsbc_csc_coefficient_generator_unit;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [13:0] val;
        logic               lst;
    } coef_t;

    logic clk;
    logic rst_n;
    int   req_idle_pct;
    int   coef_stall_pct;
    int   errors;
    coef_t coef_queue[$];

    hcg_req_if  req();
    hcg_coef_if coef();

    hsbc_csc_coefficient_generator_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .coef(coef.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint floor_div(input longint x, input int n);
        return x >>> n;
    endfunction

    function automatic longint pct_of(input logic [6:0] v);
        return (v > hcg_pkg::PCT_MAX) ? 100 : longint'(v);
    endfunction

    task automatic predict_coefs(input logic rgb, input logic [2:0] cs_in,
                                 input logic [6:0] b, input logic [6:0] c,
                                 input logic [6:0] s, input logic [6:0] h);
        longint hsbc[4][4];
        longint work[4][4];
        longint br, ct, st, hu, sn, cs, k11, k12, k21, acc, m;
        int sel;
        coef_t e;
        br = pct_of(b) * 128 / 100 - 64;
        ct = pct_of(c) * 180 / 100 - 90 + 128;
        st = pct_of(s) * 128 / 100 - 64 + 128;
        hu = pct_of(h) * 58 / 100;
        sel = (cs_in > 3) ? int'(hcg_pkg::CS_601_LIM) : int'(cs_in);
        sn = hcg_pkg::SINE_LUT[hu];
        cs = hcg_pkg::COS_LUT[hu];
        k11 = floor_div(ct * st * cs, 16);
        k12 = floor_div(ct * st * sn, 16);
        k21 = floor_div(-ct * st * sn, 16);
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++)
                hsbc[j][i] = 0;
        hsbc[0][0] = ct * 8;
        hsbc[0][3] = br * 2048 + (1024 - ct * 8) * 16;
        hsbc[1][1] = k11;
        hsbc[1][2] = k12;
        hsbc[1][3] = (1024 - (k11 + k12)) * 128;
        hsbc[2][1] = k21;
        hsbc[2][2] = k11;
        hsbc[2][3] = (1024 - (k21 + k11)) * 128;
        hsbc[3][3] = 1024;
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++)
            begin
                if (rgb)
                begin
                    work[j][i] = 0;
                    for (int k = 0; k < 4; k++)
                        work[j][i] += floor_div(hsbc[j][k] * longint'(hcg_pkg::R2Y[k][i]),
                                                10);
                end
                else
                    work[j][i] = hsbc[j][i];
            end
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 4; i++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                begin
                    m = hcg_pkg::Y2R[sel][j][k];
                    if (k == 3)
                        m *= 64;
                    acc += m * work[k][i];
                end
                if (i == 3)
                begin
                    acc = floor_div(acc, 16);
                    if (acc > hcg_pkg::OFFS_MAX) acc = hcg_pkg::OFFS_MAX;
                    if (acc < hcg_pkg::OFFS_MIN) acc = hcg_pkg::OFFS_MIN;
                end
                else
                begin
                    acc = floor_div(acc, 10);
                    if (acc > hcg_pkg::GAIN_MAX) acc = hcg_pkg::GAIN_MAX;
                    if (acc < hcg_pkg::GAIN_MIN) acc = hcg_pkg::GAIN_MIN;
                end
                e.idx = 4'(j * 4 + i);
                e.val = 14'(acc);
                e.lst = (e.idx == hcg_pkg::COEF_LAST);
                coef_queue.push_back(e);
            end
    endtask

    task automatic send_settings(input logic rgb, input logic [2:0] cs_in,
                                 input logic [6:0] b, input logic [6:0] c,
                                 input logic [6:0] s, input logic [6:0] h);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.rgb_input <= rgb;
        req.csc_standard <= cs_in;
        req.brightness <= b;
        req.contrast_level <= c;
        req.saturation_level <= s;
        req.hue_level <= h;
        do
            @(posedge clk);
        while (!req.ready);
        predict_coefs(rgb, cs_in, b, c, s, h);
        @(negedge clk);
    endtask

    always @(negedge clk)
        coef.ready <= ($urandom_range(99) >= coef_stall_pct);

    always @(posedge clk)
    begin
        coef_t e;
        if (rst_n && coef.valid && coef.ready)
        begin
            if (coef_queue.size() == 0)
            begin
                $display("%0t: unexpected coefficient idx %0d val %0d", $time,
                         coef.coef_index, coef.coef_value);
                errors++;
            end
            else
            begin
                e = coef_queue.pop_front();
                if (coef.coef_index !== e.idx || coef.coef_value !== e.val
                    || coef.last !== e.lst)
                begin
                    $display("%0t: expected idx %0d val %0d last %0b, %s %0d val %0d last %0b",
                             $time, e.idx, e.val, e.lst, "actual idx", coef.coef_index,
                             coef.coef_value, coef.last);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (coef_queue.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic test_directed();
        logic [6:0] ext[4];
        ext = '{7'd0, 7'd100, 7'd101, 7'd127};
        for (int cs_i = 0; cs_i < 8; cs_i++)
            send_settings(cs_i[0], 3'(cs_i), 7'd50, 7'd50, 7'd50, 7'd50);
        for (int k = 0; k < 4; k++)
        begin
            send_settings(1'b0, 3'd0, ext[k], ext[3 - k], ext[k], ext[(k + 1) % 4]);
            send_settings(1'b1, 3'd3, ext[k], ext[k], ext[3 - k], ext[(k + 2) % 4]);
        end
        send_settings(1'b1, 3'd1, 7'd127, 7'd127, 7'd127, 7'd127);
        send_settings(1'b0, 3'd2, 7'd0, 7'd0, 7'd0, 7'd0);
        wait_drained();
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        logic [6:0] f[4];
        req_idle_pct = idle;
        coef_stall_pct = stall;
        for (int k = 0; k < n; k++)
        begin
            for (int q = 0; q < 4; q++)
                f[q] = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(100));
            send_settings(1'($urandom), 3'($urandom), f[0], f[1], f[2], f[3]);
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        req_idle_pct = 0;
        coef_stall_pct = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.rgb_input = 1'b0;
        req.csc_standard = 3'd0;
        req.brightness = 7'd0;
        req.contrast_level = 7'd0;
        req.saturation_level = 7'd0;
        req.hue_level = 7'd0;
        coef.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(90, 0, 0);
        test_random(90, 56, 0);
        test_random(90, 0, 56);
        test_random(100, 9, 9);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
